/* rtl/core/sorted_list_insert_remove_unit_assert.svh */
`ifndef SORTED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH
`define SORTED_LIST_INSERT_REMOVE_UNIT_ASSERT_SVH

// Same-cycle check, clocked on i_clk, masked during reset.
`define SLIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check, clocked on i_clk, masked during reset.
`define SLIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/slir_pkg.sv */
package slir_pkg;

    localparam int KEY_W      = 16;
    localparam int TAG_W      = 16;
    localparam int POS_W      = 6;
    localparam int CNT_OUT_W  = 6;
    localparam int DEF_CAPACITY = 32;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_entry;

    // what each cell hands to its right-hand neighbour
    typedef struct packed {
        logic   le;     // occupied and key <= incoming key
        t_entry entry;
    } t_link;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry entry;
    } t_cmd;

endpackage

/* rtl/core/slir_if.sv */
interface slir_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [slir_pkg::KEY_W-1:0]  sort_key;
    logic [slir_pkg::TAG_W-1:0]  item_tag;
    logic [slir_pkg::POS_W-1:0]  position;

    modport source (output valid, opcode, sort_key, item_tag, position, input ready);
    modport sink   (input valid, opcode, sort_key, item_tag, position, output ready);
endinterface

interface slir_out_if;
    logic                          valid;
    logic                          ready;
    slir_pkg::t_status             status;
    logic [slir_pkg::TAG_W-1:0]    removed_tag;
    logic [slir_pkg::KEY_W-1:0]    removed_key;
    logic [slir_pkg::CNT_OUT_W-1:0] entry_count;

    modport source (output valid, status, removed_tag, removed_key, entry_count, input ready);
    modport sink   (input valid, status, removed_tag, removed_key, entry_count, output ready);
endinterface

/* rtl/core/slir_cell.sv */
module slir_cell (
    input  logic            i_clk,
    input  slir_pkg::t_cmd  i_cmd,
    input  logic            i_occupied,
    input  logic            i_shift_out,   // at or right of the removed slot
    input  slir_pkg::t_link i_left,
    input  slir_pkg::t_entry i_right,
    output slir_pkg::t_link o_link
);

    slir_pkg::t_entry r_entry;
    slir_pkg::t_entry n_entry;
    logic             w_le;

    assign w_le   = i_occupied && (r_entry.key <= i_cmd.entry.key);
    assign o_link = '{le: w_le, entry: r_entry};

    always_comb begin
        n_entry = r_entry;
        if (i_cmd.ins && !w_le) begin
            // first slot past the equal-or-less run takes the new entry; later slots take their left neighbour's
            n_entry = i_left.le ? i_cmd.entry : i_left.entry;
        end else if (i_cmd.rem && i_shift_out) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

/* rtl/core/sorted_list_insert_remove_unit.sv */
// Sorted insertion list: a row of CAPACITY cells updated in parallel.
// The result of an input transfer is registered in the output register.
// Throughput: 1 item per cycle; each item updates the whole cell row in
//   parallel, and a held output result stalls input only when the sink is not ready.
// Reset (i_rst_n low, synchronous): entry count and output valid cleared;
//   cell contents are left as they are and only read below the count.
module sorted_list_insert_remove_unit #(
    parameter int CAPACITY = slir_pkg::DEF_CAPACITY
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    slir_in_if.sink          i_in,
    slir_out_if.source       o_out
);

`include "sorted_list_insert_remove_unit_assert.svh"

    // count must hold CAPACITY itself; comparisons run at the wider of
    // count and position widths
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > slir_pkg::POS_W) ? CW : slir_pkg::POS_W;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    // output register
    logic                          r_out_valid;
    slir_pkg::t_status             r_status;
    slir_pkg::t_status             n_status;
    slir_pkg::t_entry              r_removed;
    slir_pkg::t_entry              n_removed;
    logic [slir_pkg::CNT_OUT_W-1:0] r_count_out;

    logic                   w_xfer;
    logic                   w_is_ins;
    logic                   w_is_rem;
    logic                   w_full;
    logic                   w_pos_ok;
    logic [CMPW-1:0]        w_pos;
    slir_pkg::t_cmd         w_cmd;
    slir_pkg::t_link        w_link [CAPACITY];
    logic [CAPACITY-1:0]    w_sel;

    // --- handshake: the output register parts the two sides -------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_xfer     = i_in.valid && i_in.ready;

    // --- decode -------------------------------------------------------------
    assign w_pos    = CMPW'(i_in.position);
    assign w_full   = (r_count == CW'(CAPACITY));
    assign w_pos_ok = (w_pos != '0) && (w_pos <= CMPW'(r_count));
    assign w_is_ins = w_xfer && (i_in.opcode == slir_pkg::OP_INSERT);
    assign w_is_rem = w_xfer && (i_in.opcode == slir_pkg::OP_REMOVE);

    // full inserts and out-of-range removes leave the row untouched
    assign w_cmd = '{
        ins:   w_is_ins && !w_full,
        rem:   w_is_rem && w_pos_ok,
        entry: '{key: i_in.sort_key, tag: i_in.item_tag}
    };

    // --- cell row -------------------------------------------------------------
    // Cell i sees its left neighbour's compare result and entry for an
    // insert shift, and its right neighbour's entry for a remove shift.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        localparam logic [CMPW-1:0] SLOT_POS = CMPW'(gi + 1);  // 1-based place

        slir_pkg::t_link  w_left;
        slir_pkg::t_entry w_right;
        logic             w_occupied;
        logic             w_shift_out;

        if (gi == 0) begin : g_head
            // head: nothing to the left, so "left <= key" always holds
            assign w_left = '{le: 1'b1, entry: '0};
        end else begin : g_body
            assign w_left = w_link[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_inner
            assign w_right = w_link[gi+1].entry;
        end

        assign w_occupied  = (CW'(gi) < r_count);
        assign w_shift_out = (SLOT_POS >= w_pos);
        assign w_sel[gi]   = (SLOT_POS == w_pos);

        slir_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_occupied  (w_occupied),
            .i_shift_out (w_shift_out),
            .i_left      (w_left),
            .i_right     (w_right),
            .o_link      (w_link[gi])
        );
    end

    // --- result -------------------------------------------------------------
    always_comb begin
        n_removed = '0;
        n_count   = r_count;
        n_status  = slir_pkg::ST_OK;
        if (w_is_ins) begin
            if (w_full) begin
                n_status = slir_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (w_is_rem) begin
            if (w_pos_ok) begin
                n_count = r_count - CW'(1);
                // one-hot select across the row
                for (int k = 0; k < CAPACITY; k++) begin
                    n_removed = n_removed | (w_sel[k] ? w_link[k].entry : '0);
                end
            end else begin
                n_status = slir_pkg::ST_NOT_FOUND;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_xfer) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_xfer) begin
            r_status    <= n_status;
            r_removed   <= n_removed;
            r_count_out <= slir_pkg::CNT_OUT_W'(n_count);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.removed_tag = r_removed.tag;
    assign o_out.removed_key = r_removed.key;
    assign o_out.entry_count = r_count_out;

    // --- checks -----------------------------------------------------------
    `SLIR_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(CAPACITY), "count above capacity")
    `SLIR_ASSERT_NEXT(a_full_hold, w_is_ins && w_full, $stable(r_count), "full insert moved count")
    `SLIR_ASSERT_NEXT(a_ins_inc, w_is_ins && !w_full, r_count == $past(r_count) + CW'(1), "insert count")
    `SLIR_ASSERT_NEXT(a_rem_dec, w_is_rem && w_pos_ok, r_count == $past(r_count) - CW'(1), "remove count")

endmodule

/* dv/tb_sorted_list_insert_remove_unit.sv */
module tb_sorted_list_insert_remove_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import slir_pkg::*;

    localparam int CAP          = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1000;
    // cycles without a transfer on either channel before the run is abandoned
    localparam int STALL_LIMIT  = 5000;
    // settle time after the last result; the block has a single register stage
    localparam int DRAIN_CYCLES = 8;

    // one command towards the list
    typedef struct packed {
        logic                 op;
        logic [KEY_W-1:0]     key;
        logic [TAG_W-1:0]     tag;
        logic [POS_W-1:0]     pos;
    } t_list_cmd;

    // one result from the list
    typedef struct packed {
        t_status              status;
        logic [TAG_W-1:0]     rtag;
        logic [KEY_W-1:0]     rkey;
        logic [CNT_OUT_W-1:0] count;
    } t_list_result;

    // directed row: sent reps times; fixed result used only where typed is set
    typedef struct {
        t_list_cmd    cmd;
        int unsigned  reps;
        bit           typed;
        t_list_result res;
    } t_dir_row;

    // bias of a random segment towards inserts or removes
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    // receiver back-pressure patterns
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} t_rx_pattern;

    logic i_clk;
    logic i_rst_n;

    slir_in_if  u_in_if ();
    slir_out_if u_out_if ();

    sorted_list_insert_remove_unit #(
        .CAPACITY (CAP)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in_if),
        .o_out   (u_out_if)
    );

    // Shadow copy of the list, updated at each accepted input transfer.
    logic [KEY_W-1:0] list_keys [CAP];
    logic [TAG_W-1:0] list_tags [CAP];
    int               list_count = 0;

    // results still owed by the block, oldest first
    t_list_result     owed_results [$];
    t_dir_row         dir_rows [$];

    int unsigned      n_errors    = 0;
    int unsigned      idle_cycles = 0;
    int unsigned      burst_left  = 0;

    t_rx_pattern      rx_pattern = RX_OPEN;
    int unsigned      rx_left    = 0;
    int unsigned      rx_phase   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one command to the shadow list and return the result it owes.
    // Inserts land after every key <= the new one, so ties keep arrival order.
    function automatic t_list_result apply_to_list(t_list_cmd cmd);
        t_list_result r;
        int slot;
        int i;
        r        = '0;
        r.status = ST_OK;
        if (cmd.op == OP_INSERT) begin
            if (list_count >= CAP) begin
                r.status = ST_FULL;
            end else begin
                slot = 0;
                while (slot < list_count && list_keys[slot] <= cmd.key) slot++;
                for (i = list_count; i > slot; i--) begin
                    list_keys[i] = list_keys[i-1];
                    list_tags[i] = list_tags[i-1];
                end
                list_keys[slot] = cmd.key;
                list_tags[slot] = cmd.tag;
                list_count++;
            end
        end else begin
            // position is 1-based; zero and anything past the tail miss
            if (cmd.pos == 0 || int'(cmd.pos) > list_count) begin
                r.status = ST_NOT_FOUND;
            end else begin
                slot   = int'(cmd.pos) - 1;
                r.rkey = list_keys[slot];
                r.rtag = list_tags[slot];
                for (i = slot; i + 1 < list_count; i++) begin
                    list_keys[i] = list_keys[i+1];
                    list_tags[i] = list_tags[i+1];
                end
                list_count--;
            end
        end
        r.count = CNT_OUT_W'(list_count);
        return r;
    endfunction

    function automatic void add_row(logic op, logic [KEY_W-1:0] key, logic [TAG_W-1:0] tag,
                                    logic [POS_W-1:0] pos, int unsigned reps, bit typed,
                                    t_status st, logic [TAG_W-1:0] rtag,
                                    logic [KEY_W-1:0] rkey, logic [CNT_OUT_W-1:0] cnt);
        t_dir_row row;
        row.cmd   = '{op: op, key: key, tag: tag, pos: pos};
        row.reps  = reps;
        row.typed = typed;
        row.res   = '{status: st, rtag: rtag, rkey: rkey, count: cnt};
        dir_rows.push_back(row);
    endfunction

    task automatic check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
        end
    endtask

    // Sender pacing: bursts of random length, mostly followed by a short gap.
    // With drain set the sender also holds off until nothing is owed.
    task automatic pace(bit drain);
        int unsigned gap;
        if (burst_left == 0 || drain) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 24);
            if (drain || $urandom_range(0, 3) != 0) begin
                gap = $urandom_range(1, 6);
                u_in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (drain && owed_results.size() != 0) @(posedge i_clk);
            end
        end
        burst_left--;
    endtask

    // Present one command and hold it until the transfer; predict on acceptance.
    task automatic send_cmd(t_list_cmd cmd, output t_list_result res);
        u_in_if.valid    <= 1'b1;
        u_in_if.opcode   <= cmd.op;
        u_in_if.sort_key <= cmd.key;
        u_in_if.item_tag <= cmd.tag;
        u_in_if.position <= cmd.pos;
        do @(posedge i_clk); while (!u_in_if.ready);
        res = apply_to_list(cmd);
    endtask

    // Receiver: switches between back-pressure patterns at random.
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_pattern <= t_rx_pattern'($urandom_range(0, 3));
            rx_left    <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        rx_phase <= rx_phase + 1;
        case (rx_pattern)
            RX_OPEN:   u_out_if.ready <= 1'b1;
            RX_COIN:   u_out_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: u_out_if.ready <= ($urandom_range(0, 3) == 0);
            default:   u_out_if.ready <= (rx_phase % 3 != 2);
        endcase
    end

    // Result checker: every output transfer against the oldest owed result.
    always @(posedge i_clk) begin : result_check
        t_list_result exp;
        if (i_rst_n && u_out_if.valid && u_out_if.ready) begin
            if (owed_results.size() == 0) begin
                n_errors++;
                $display("%0t: result with none owed, expected nothing, got %0h/%0h/%0h/%0h",
                         $time, u_out_if.status, u_out_if.removed_tag,
                         u_out_if.removed_key, u_out_if.entry_count);
            end else begin
                exp = owed_results.pop_front();
                check_field("status",      exp.status, u_out_if.status);
                check_field("removed_tag", exp.rtag,   u_out_if.removed_tag);
                check_field("removed_key", exp.rkey,   u_out_if.removed_key);
                check_field("entry_count", exp.count,  u_out_if.entry_count);
            end
        end
    end

    // Watchdog: gives up after a long stretch with no transfer anywhere.
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((u_in_if.valid && u_in_if.ready) || (u_out_if.valid && u_out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        t_list_result res;
        t_list_cmd    cmd;
        t_mix         mix;
        int unsigned  seg_left;
        int unsigned  ins_pct;

        i_rst_n          <= 1'b0;
        u_in_if.valid    <= 1'b0;
        u_in_if.opcode   <= OP_INSERT;
        u_in_if.sort_key <= '0;
        u_in_if.item_tag <= '0;
        u_in_if.position <= '0;
        seg_left = 0;
        mix      = MIX_EVEN;

        // Directed rows. Fixed results only where obvious; the rest is predicted.
        // empty list: remove misses, position zero too
        add_row(OP_REMOVE, '0, '0, 6'd1, 1, 1, ST_NOT_FOUND, '0, '0, 6'd0);
        add_row(OP_REMOVE, '0, '0, 6'd0, 1, 1, ST_NOT_FOUND, '0, '0, 6'd0);
        // key extremes, and a tie on 0x8000 (unused position field set high)
        add_row(OP_INSERT, 16'hFFFF, 16'hFFFF, 6'd0,  1, 1, ST_OK, '0, '0, 6'd1);
        add_row(OP_INSERT, 16'h0000, 16'h0000, 6'h3F, 1, 1, ST_OK, '0, '0, 6'd2);
        add_row(OP_INSERT, 16'h8000, 16'h1234, 6'd0,  1, 1, ST_OK, '0, '0, 6'd3);
        add_row(OP_INSERT, 16'h8000, 16'h5678, 6'd0,  1, 1, ST_OK, '0, '0, 6'd4);
        // positions past the tail, the field maximum and zero all miss
        add_row(OP_REMOVE, 16'hFFFF, 16'hFFFF, 6'd5,  1, 1, ST_NOT_FOUND, '0, '0, 6'd4);
        add_row(OP_REMOVE, '0, '0, 6'h3F, 1, 1, ST_NOT_FOUND, '0, '0, 6'd4);
        add_row(OP_REMOVE, '0, '0, 6'd0,  1, 1, ST_NOT_FOUND, '0, '0, 6'd4);
        // the tie leaves in arrival order
        add_row(OP_REMOVE, '0, '0, 6'd2, 1, 1, ST_OK, 16'h1234, 16'h8000, 6'd3);
        add_row(OP_REMOVE, '0, '0, 6'd2, 1, 1, ST_OK, 16'h5678, 16'h8000, 6'd2);
        // tie at the top key goes behind the older entry
        add_row(OP_INSERT, 16'hFFFF, 16'hAAAA, 6'h3F, 1, 1, ST_OK, '0, '0, 6'd3);
        add_row(OP_REMOVE, '0, '0, 6'd3, 1, 1, ST_OK, 16'hAAAA, 16'hFFFF, 6'd2);
        // fill to capacity, then inserts bounce
        add_row(OP_INSERT, 16'h7FFF, 16'h5555, 6'd0, CAP - 2, 0, ST_OK, '0, '0, '0);
        add_row(OP_INSERT, 16'h0001, 16'h0F0F, 6'd0, 1, 1, ST_FULL, '0, '0, 6'(CAP));
        add_row(OP_INSERT, 16'hFFFF, 16'hFFFF, 6'd0, 1, 1, ST_FULL, '0, '0, 6'(CAP));
        add_row(OP_REMOVE, '0, '0, 6'(CAP + 1), 1, 1, ST_NOT_FOUND, '0, '0, 6'(CAP));
        // tail and head of a full list, then drain from the head
        add_row(OP_REMOVE, '0, '0, 6'(CAP), 1, 1, ST_OK, 16'hFFFF, 16'hFFFF, 6'(CAP - 1));
        add_row(OP_REMOVE, '0, '0, 6'd1, 1, 1, ST_OK, 16'h0000, 16'h0000, 6'(CAP - 2));
        add_row(OP_REMOVE, '0, '0, 6'd1, CAP - 2, 0, ST_OK, '0, '0, '0);
        add_row(OP_REMOVE, '0, '0, 6'd1, 1, 1, ST_NOT_FOUND, '0, '0, 6'd0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            repeat (dir_rows[r].reps) begin
                pace(1'b0);
                send_cmd(dir_rows[r].cmd, res);
                owed_results.push_back(dir_rows[r].typed ? dir_rows[r].res : res);
            end
        end

        // Random segments, each leaning towards filling, draining or neither,
        // so the list keeps swinging between empty and full.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (seg_left == 0) begin
                mix      = t_mix'($urandom_range(0, 2));
                seg_left = $urandom_range(20, 80);
            end
            seg_left--;
            case (mix)
                MIX_FILL:  ins_pct = 85;
                MIX_DRAIN: ins_pct = 15;
                default:   ins_pct = 50;
            endcase
            cmd.op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
            // narrow keys give plenty of ties; extremes test the ends of the order
            case ($urandom_range(0, 3))
                0:       cmd.key = KEY_W'($urandom_range(0, 7));
                1:       cmd.key = $urandom_range(0, 1) ? '1 : '0;
                default: cmd.key = KEY_W'($urandom());
            endcase
            cmd.tag = TAG_W'($urandom());
            cmd.pos = POS_W'($urandom());
            // removes mostly hit a live entry; the rest is any position value
            if (cmd.op == OP_REMOVE && list_count != 0 && $urandom_range(0, 9) != 0)
                cmd.pos = POS_W'($urandom_range(1, list_count));
            // half way through, hold off until the block has caught up
            pace(n == RANDOM_ITEMS / 2);
            send_cmd(cmd, res);
            owed_results.push_back(res);
        end
        u_in_if.valid <= 1'b0;

        while (owed_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/slir_pkg.sv
rtl/core/slir_if.sv
rtl/core/slir_cell.sv
rtl/core/sorted_list_insert_remove_unit.sv
dv/tb_sorted_list_insert_remove_unit.sv
